FILE: design/rtw_pkg.sv
package rtw_pkg;

  localparam int MOD_STEPS = 32;
  localparam int DIV_STEPS = 32;
  localparam int LOG_STEPS = 24;
  localparam int POW_STEPS = 24;

  localparam logic [2:0] CFG_SEGMENT_START = 3'd0;
  localparam logic [2:0] CFG_FRAME_LENGTH  = 3'd1;
  localparam logic [2:0] CFG_WARP_EXPONENT = 3'd2;
  localparam logic [2:0] CFG_LATE_START    = 3'd3;
  localparam logic [2:0] CFG_EARLY_END     = 3'd4;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BEFORE      = 2'd1;
  localparam logic [1:0] ST_ZERO_FRAME  = 2'd2;

  localparam logic [23:0] MIN_INTENSITY = 24'd655;
  localparam logic signed [18:0] ONE_Q16 = 19'sd65536;

  // Values that travel along the whole pipeline beside the arithmetic.
  typedef struct packed {
    logic [31:0] date;
    logic [1:0]  status;
    logic [31:0] base;
  } carry_t;

  // Integer square root, only evaluated at elaboration for the root table.
  function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    x   = x_in;
    res = 64'd0;
    bv  = 64'd1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 64'd0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q0.32, built by k truncating square roots starting from 0.5.
  function automatic logic [31:0] root_q32(input int k);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      r = isqrt64(r << 32);
    end
    return r[31:0];
  endfunction

endpackage

FILE: design/rubato_time_warp.sv
// Channel | Direction | Transfer content
// in_     | slave     | tdata[31:0] date_in (unsigned Q24.8)
// out_    | master    | tdata[31:0] warped_date, tdata[33:32] status, rest zero
// cfg_    | write     | cfg_addr selects register, cfg_wdata[31:0] holds its value
//
// One date is accepted every cycle while the output register can advance. The pipeline
// has 121 register stages. Most of them are the bit-serial remainder and quotient chains
// (32 stages each), the log2 squaring chain and the exp2 product chain (24 stages each).
// Reset is synchronous and clears only the valid bits and the configuration registers.
// A stall on the output freezes every stage at once, so no item is lost or repeated, and
// in_tready follows the output register.
module rubato_time_warp
  import rtw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] date_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] warped_date, [33:32] status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // Configuration registers.
  logic [31:0] seg_start_r;
  logic [31:0] frame_r;
  logic [15:0] warp_r;
  logic [17:0] late_r;
  logic [17:0] early_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_start_r <= 32'd0;
      frame_r     <= 32'd256;
      warp_r      <= 16'd256;
      late_r      <= 18'd0;
      early_r     <= 18'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SEGMENT_START: seg_start_r <= cfg_wdata;
        CFG_FRAME_LENGTH:  frame_r     <= cfg_wdata;
        CFG_WARP_EXPONENT: warp_r      <= cfg_wdata[15:0];
        CFG_LATE_START:    late_r      <= cfg_wdata[17:0];
        CFG_EARLY_END:     early_r     <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  // Clamped operands. The user must change configuration only while the pipeline is empty;
  // the block does not enforce this. These are read directly by every stage.
  logic signed [16:0] iexp;
  logic signed [16:0] iabs;
  logic [23:0]        expo;
  logic signed [17:0] ls_raw;
  logic signed [17:0] ee_raw;
  logic signed [18:0] ls;
  logic signed [18:0] ee;
  logic signed [19:0] span;

  always_comb begin
    iexp   = {warp_r[15], warp_r};
    iabs   = iexp[16] ? -iexp : iexp;
    expo   = (warp_r == 16'd0) ? MIN_INTENSITY : {iabs[15:0], 8'h00};
    ls_raw = late_r;
    ee_raw = early_r;
    ls     = ls_raw[17] ? 19'sd0 : {1'b0, ls_raw};
    ee     = (ee_raw > 18'sd65536) ? ONE_Q16 : {ee_raw[17], ee_raw};
    if (ls_raw >= ee_raw) begin
      ls = 19'sd0;
      ee = ONE_Q16;
    end
    span = {ee[18], ee} - {ls[18], ls};
  end

  // The whole pipeline advances together whenever the output register can move.
  logic adv;
  logic o_vld_r;
  assign adv       = !o_vld_r || out_tready;
  assign in_tready = adv;

  // Entry stage: offset from the grid start and pass-through classification.
  // Index 0 of the remainder chain is this stage.
  logic        m_vld_r  [MOD_STEPS+1];
  carry_t      m_cr_r   [MOD_STEPS+1];
  logic [31:0] m_diff_r [MOD_STEPS+1];
  logic [31:0] m_rem_r  [MOD_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r[0] <= 1'b0;
    end else if (adv) begin
      m_vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_cr_r[0].date   <= in_tdata[31:0];
      m_cr_r[0].base   <= 32'd0;
      m_cr_r[0].status <= (frame_r == 32'd0) ? ST_ZERO_FRAME :
                          (in_tdata[31:0] < seg_start_r) ? ST_BEFORE : ST_OK;
      m_diff_r[0]      <= in_tdata[31:0] - seg_start_r;
      m_rem_r[0]       <= 32'd0;
    end
  end

  // Remainder (date - start) mod frame, one dividend bit per stage.
  for (genvar i = 1; i <= MOD_STEPS; i++) begin : g_mod
    logic [32:0] sh;
    logic [32:0] sub;
    always_comb begin
      sh  = {m_rem_r[i-1], m_diff_r[i-1][MOD_STEPS-i]};
      sub = sh - {1'b0, frame_r};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        m_vld_r[i] <= 1'b0;
      end else if (adv) begin
        m_vld_r[i] <= m_vld_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        m_cr_r[i]   <= m_cr_r[i-1];
        m_diff_r[i] <= m_diff_r[i-1];
        m_rem_r[i]  <= (sh >= {1'b0, frame_r}) ? sub[31:0] : sh[31:0];
      end
    end
  end

  // Quotient t = local * 2^32 / frame, one quotient bit per stage.
  logic        d_vld_r [DIV_STEPS+1];
  carry_t      d_cr_r  [DIV_STEPS+1];
  logic [31:0] d_rem_r [DIV_STEPS+1];
  logic [31:0] d_q_r   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r[0] <= 1'b0;
    end else if (adv) begin
      d_vld_r[0] <= m_vld_r[MOD_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_cr_r[0].date   <= m_cr_r[MOD_STEPS].date;
      d_cr_r[0].status <= m_cr_r[MOD_STEPS].status;
      d_cr_r[0].base   <= m_cr_r[MOD_STEPS].date - m_rem_r[MOD_STEPS];
      d_rem_r[0]       <= m_rem_r[MOD_STEPS];
      d_q_r[0]         <= 32'd0;
    end
  end

  for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
    logic [32:0] sh;
    logic [32:0] sub;
    logic        ge;
    always_comb begin
      sh  = {d_rem_r[i-1], 1'b0};
      sub = sh - {1'b0, frame_r};
      ge  = (sh >= {1'b0, frame_r});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[i] <= 1'b0;
      end else if (adv) begin
        d_vld_r[i] <= d_vld_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_cr_r[i]  <= d_cr_r[i-1];
        d_rem_r[i] <= ge ? sub[31:0] : sh[31:0];
        d_q_r[i]   <= {d_q_r[i-1][30:0], ge};
      end
    end
  end

  // log2 of t: leading one normalization, then one fraction bit per squaring stage.
  logic        l_vld_r  [LOG_STEPS+1];
  carry_t      l_cr_r   [LOG_STEPS+1];
  logic [31:0] l_y_r    [LOG_STEPS+1];
  logic [4:0]  l_n_r    [LOG_STEPS+1];
  logic [23:0] l_frac_r [LOG_STEPS+1];
  logic        l_tz_r   [LOG_STEPS+1];

  logic [31:0] tq;
  logic [4:0]  lead;
  assign tq = d_q_r[DIV_STEPS];

  always_comb begin
    lead = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (tq[b]) lead = 5'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r[0] <= 1'b0;
    end else if (adv) begin
      l_vld_r[0] <= d_vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_cr_r[0]   <= d_cr_r[DIV_STEPS];
      l_y_r[0]    <= tq << (5'd31 - lead);
      l_n_r[0]    <= lead;
      l_frac_r[0] <= 24'd0;
      l_tz_r[0]   <= (tq == 32'd0);
    end
  end

  for (genvar i = 1; i <= LOG_STEPS; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] s;
    always_comb begin
      sq = l_y_r[i-1] * l_y_r[i-1];
      s  = sq[63:31];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        l_vld_r[i] <= 1'b0;
      end else if (adv) begin
        l_vld_r[i] <= l_vld_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        l_cr_r[i]   <= l_cr_r[i-1];
        l_y_r[i]    <= s[32] ? s[32:1] : s[31:0];
        l_n_r[i]    <= l_n_r[i-1];
        l_frac_r[i] <= {l_frac_r[i-1][22:0], s[32]};
        l_tz_r[i]   <= l_tz_r[i-1];
      end
    end
  end

  // Exponent p = -log2(t) * intensity, Q.24.
  logic [29:0] neg_log;
  logic [53:0] p_full;
  logic [37:0] p_val;
  assign neg_log = (30'd32 << 24) - {1'b0, l_n_r[LOG_STEPS], l_frac_r[LOG_STEPS]};
  assign p_full  = neg_log * expo;
  assign p_val   = p_full[53:16];

  // exp2 of -p: one fraction bit of p per stage, then the integer shift.
  logic        p_vld_r  [POW_STEPS+1];
  carry_t      p_cr_r   [POW_STEPS+1];
  logic [32:0] p_acc_r  [POW_STEPS+1];
  logic [23:0] p_f_r    [POW_STEPS+1];
  logic [4:0]  p_ip_r   [POW_STEPS+1];
  logic        p_zero_r [POW_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r[0] <= 1'b0;
    end else if (adv) begin
      p_vld_r[0] <= l_vld_r[LOG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_cr_r[0]   <= l_cr_r[LOG_STEPS];
      p_acc_r[0]  <= 33'h1_0000_0000;
      p_f_r[0]    <= p_val[23:0];
      p_ip_r[0]   <= p_val[28:24];
      p_zero_r[0] <= l_tz_r[LOG_STEPS] || (p_val[37:29] != 9'd0);
    end
  end

  for (genvar k = 1; k <= POW_STEPS; k++) begin : g_pow
    localparam logic [31:0] ROOT = root_q32(k);
    logic [64:0] prod;
    assign prod = p_acc_r[k-1] * ROOT;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_vld_r[k] <= 1'b0;
      end else if (adv) begin
        p_vld_r[k] <= p_vld_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        p_cr_r[k]   <= p_cr_r[k-1];
        p_acc_r[k]  <= p_f_r[k-1][POW_STEPS-k] ? prod[64:32] : p_acc_r[k-1];
        p_f_r[k]    <= p_f_r[k-1];
        p_ip_r[k]   <= p_ip_r[k-1];
        p_zero_r[k] <= p_zero_r[k-1];
      end
    end
  end

  // Power after the integer shift.
  logic        w_vld_r;
  carry_t      w_cr_r;
  logic [32:0] w_pw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_vld_r <= 1'b0;
    end else if (adv) begin
      w_vld_r <= p_vld_r[POW_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_cr_r <= p_cr_r[POW_STEPS];
      w_pw_r <= p_zero_r[POW_STEPS] ? 33'd0 : (p_acc_r[POW_STEPS] >> p_ip_r[POW_STEPS]);
    end
  end

  // Scale into the late/early window.
  logic               g1_vld_r;
  carry_t             g1_cr_r;
  logic signed [53:0] g1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
    end else if (adv) begin
      g1_vld_r <= w_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_cr_r   <= w_cr_r;
      g1_prod_r <= $signed({1'b0, w_pw_r}) * span;
    end
  end

  logic               g2_vld_r;
  carry_t             g2_cr_r;
  logic signed [19:0] g2_g_r;
  logic signed [21:0] g_sum;
  assign g_sum = $signed(g1_prod_r[53:32]) + {{3{ls[18]}}, ls};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_vld_r <= 1'b0;
    end else if (adv) begin
      g2_vld_r <= g1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g2_cr_r <= g1_cr_r;
      g2_g_r  <= g_sum[19:0];
    end
  end

  // Offset in date units.
  logic               d1_vld_r;
  carry_t             d1_cr_r;
  logic signed [52:0] d1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else if (adv) begin
      d1_vld_r <= g2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_cr_r   <= g2_cr_r;
      d1_prod_r <= g2_g_r * $signed({1'b0, frame_r});
    end
  end

  // Final sum, saturation and pass-through selection into the output register.
  logic signed [37:0] res;
  logic [31:0]        res_sat;
  always_comb begin
    res = $signed({6'd0, d1_cr_r.base}) + {{1{d1_prod_r[52]}}, d1_prod_r[52:16]};
    if (res < 38'sd0) begin
      res_sat = 32'd0;
    end else if (res > 38'sd4294967295) begin
      res_sat = 32'hFFFF_FFFF;
    end else begin
      res_sat = res[31:0];
    end
  end

  logic [31:0] o_date_r;
  logic [1:0]  o_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= d1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_status_r <= d1_cr_r.status;
      o_date_r   <= (d1_cr_r.status != ST_OK) ? d1_cr_r.date : res_sat;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {6'd0, o_status_r, o_date_r};

  // A stalled result stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // The status code never takes the unused value.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:32] != 2'd3)
    else $error("invalid status code");

  // The normalized log2 operand keeps its leading one through the squaring chain.
  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    l_vld_r[LOG_STEPS] && !l_tz_r[LOG_STEPS] |-> l_y_r[LOG_STEPS][31])
    else $error("log2 operand lost normalization");

  // The exp2 accumulator never exceeds one.
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r[POW_STEPS] |-> p_acc_r[POW_STEPS] <= 33'h1_0000_0000)
    else $error("power accumulator above one");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rtw_pkg::*;

  // The block's pipeline is 121 stages deep; the drain pause covers it.
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] date_in
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [31:0] warped_date, [33:32] status
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;

  typedef struct packed {
    logic [31:0] date;
    logic [1:0]  status;
  } warp_result_t;

  // Table rows: a date plus, where it can be read off directly, the result.
  typedef struct {
    logic [31:0] date;
    bit          known;
    logic [31:0] res_date;
    logic [1:0]  res_status;
  } date_row_t;

  warp_result_t warp_pending[$];
  int           error_count;
  bit           in_idle_en;
  bit           out_idle_en;
  bit           out_hold;

  // Shadow copy of the block's configuration.
  logic [31:0] sh_start;
  logic [31:0] sh_frame;
  logic [15:0] sh_exp;
  logic [17:0] sh_late;
  logic [17:0] sh_early;

  rubato_time_warp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run with every stall at its longest.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Truncating integer square root for the root chain of the power.
  function automatic logic [63:0] sqrt_floor(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bv;
    x   = x_in;
    res = 0;
    bv  = 64'd1 << 62;
    while (bv > x) bv = bv >> 2;
    while (bv != 0) begin
      if (x >= res + bv) begin
        x   = x - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Q0.32 fraction t raised to the Q8.16 intensity e, through log2 and exp2.
  function automatic logic [63:0] frac_power(input logic [63:0] t, input logic [63:0] e);
    int          msb;
    logic [63:0] y;
    logic [63:0] lg;
    logic [63:0] p;
    logic [63:0] f;
    logic [63:0] acc;
    logic [63:0] r;
    msb = 31;
    while (msb > 0 && t[msb] == 1'b0) msb--;
    y  = t << (31 - msb);
    lg = 0;
    for (int k = 0; k < 24; k++) begin
      y  = (y * y) >> 31;
      lg = lg << 1;
      if (y >= 64'h1_0000_0000) begin
        lg[0] = 1'b1;
        y = y >> 1;
      end
    end
    lg  = (64'(msb) << 24) | lg;
    p   = (((64'd32 << 24) - lg) * e) >> 16;
    if ((p >> 24) >= 32) return 0;
    f   = p & 64'hFF_FFFF;
    acc = 64'd1 << 32;
    r   = 64'd1 << 31;
    for (int k = 1; k <= 24; k++) begin
      r = sqrt_floor(r << 32);
      if (f[24 - k]) acc = (acc * r) >> 32;
    end
    return acc >> (p >> 24);
  endfunction

  // Expected warped date and status for one date under the shadow settings.
  function automatic warp_result_t predict_warp(input logic [31:0] date);
    warp_result_t       o;
    logic [63:0]        local_pos;
    logic [63:0]        t;
    logic [63:0]        e;
    logic [63:0]        pw;
    longint             ie;
    longint             ls_raw;
    longint             ee_raw;
    longint             ls;
    longint             ee;
    longint             g;
    longint             d;
    longint             res;
    if (sh_frame == 0) begin
      o.date = date; o.status = ST_ZERO_FRAME;
      return o;
    end
    if (date < sh_start) begin
      o.date = date; o.status = ST_BEFORE;
      return o;
    end
    local_pos = 64'(date - sh_start) % 64'(sh_frame);
    t  = (local_pos << 32) / 64'(sh_frame);
    ie = longint'($signed(sh_exp));
    e  = (ie == 0) ? 64'(MIN_INTENSITY) : (64'(ie < 0 ? -ie : ie) << 8);
    ls_raw = longint'($signed(sh_late));
    ee_raw = longint'($signed(sh_early));
    ls = ls_raw < 0 ? 0 : ls_raw;
    ee = ee_raw > 65536 ? 65536 : ee_raw;
    if (ls_raw >= ee_raw) begin
      ls = 0;
      ee = 65536;
    end
    pw  = (t == 0) ? 0 : frac_power(t, e);
    // Arithmetic right shifts floor toward minus infinity, as the block does.
    g   = ((longint'(pw) * (ee - ls)) >>> 32) + ls;
    d   = (g * longint'(sh_frame)) >>> 16;
    res = longint'(date) - longint'(local_pos) + d;
    if (res < 0) res = 0;
    if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
    o.date   = res[31:0];
    o.status = ST_OK;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_SEGMENT_START: sh_start = val;
      CFG_FRAME_LENGTH:  sh_frame = val;
      CFG_WARP_EXPONENT: sh_exp   = val[15:0];
      CFG_LATE_START:    sh_late  = val[17:0];
      default:           sh_early = val[17:0];
    endcase
  endtask

  task automatic write_all(input logic [31:0] st, input logic [31:0] fr, input logic [15:0] ex,
                           input logic [17:0] lt, input logic [17:0] er);
    write_reg(CFG_SEGMENT_START, st);
    write_reg(CFG_FRAME_LENGTH, fr);
    write_reg(CFG_WARP_EXPONENT, {16'd0, ex});
    write_reg(CFG_LATE_START, {14'd0, lt});
    write_reg(CFG_EARLY_END, {14'd0, er});
  endtask

  // Offers one date, holding valid until the transfer, with optional sender gaps.
  // Valid stays high between back-to-back dates, so it is never lowered and
  // raised again in the same step.
  task automatic send_date(input logic [31:0] date, input warp_result_t want);
    if (in_idle_en && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= date;
    do @(posedge clk); while (!in_tready);
    warp_pending.push_back(want);
  endtask

  task automatic send_predicted(input logic [31:0] date);
    send_date(date, predict_warp(date));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (warp_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random date mostly near the frame grid, sometimes anywhere.
  function automatic logic [31:0] pick_date();
    logic [31:0] span;
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return sh_start - $urandom_range(0, 300);
      2:       return sh_start + (sh_frame * $urandom_range(0, 6));
      default: begin
        span = (sh_frame > 32'h0100_0000 || sh_frame == 0) ? 32'h0100_0000 : sh_frame;
        return sh_start + span * $urandom_range(0, 6) + $urandom_range(0, span);
      end
    endcase
  endfunction

  // Output side: check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    warp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (warp_pending.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], 32'h0);
      end else begin
        want = warp_pending.pop_front();
        if (out_tdata[31:0] !== want.date)
          report_mismatch("warped_date", out_tdata[31:0], want.date);
        if (out_tdata[33:32] !== want.status)
          report_mismatch("status", {30'd0, out_tdata[33:32]}, {30'd0, want.status});
      end
    end
  end

  // Receiver readiness: random stall bursts, a long hold-off when asked.
  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (out_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        out_hold = 1'b0;
      end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    date_row_t   rows[$];
    logic [31:0] dates[$];
    warp_result_t want;
    error_count = 0;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    out_hold    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    sh_start = 0; sh_frame = 256; sh_exp = 16'd256; sh_late = 0; sh_early = 18'd65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under reset settings: identity warp on a unit frame, so
    // a date on the grid maps to itself.
    rows = '{
      '{32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
      '{32'h0000_0100, 1'b1, 32'h0000_0100, ST_OK},
      '{32'h0000_0080, 1'b0, 32'h0, ST_OK},
      '{32'h0000_00FF, 1'b0, 32'h0, ST_OK},
      '{32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
      '{32'hFFFF_FF00, 1'b1, 32'hFFFF_FF00, ST_OK},
      '{32'h5555_5555, 1'b0, 32'h0, ST_OK},
      '{32'hAAAA_AAAA, 1'b0, 32'h0, ST_OK}
    };
    foreach (rows[i]) begin
      want = rows[i].known ? warp_result_t'{rows[i].res_date, rows[i].res_status}
                           : predict_warp(rows[i].date);
      send_date(rows[i].date, want);
    end
    wait_drained();

    // Zero frame length passes dates through with its own status.
    write_reg(CFG_FRAME_LENGTH, 32'h0);
    rows = '{'{32'h0, 1'b1, 32'h0, ST_ZERO_FRAME},
             '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, ST_ZERO_FRAME}};
    foreach (rows[i]) send_date(rows[i].date, warp_result_t'{rows[i].res_date, rows[i].res_status});
    wait_drained();

    // Dates before the start pass through; others exercise the bound clamps.
    write_all(32'h8000_0000, 32'h0000_1000, 16'h8000, 18'h3FFFF, 18'h1FFFF);
    rows = '{'{32'h0, 1'b1, 32'h0, ST_BEFORE},
             '{32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_BEFORE},
             '{32'h8000_0800, 1'b0, 32'h0, ST_OK},
             '{32'h8000_0001, 1'b0, 32'h0, ST_OK}};
    foreach (rows[i]) begin
      want = rows[i].known ? warp_result_t'{rows[i].res_date, rows[i].res_status}
                           : predict_warp(rows[i].date);
      send_date(rows[i].date, want);
    end
    wait_drained();

    // Zero intensity, crossed negative bounds, and the largest exponent.
    write_all(32'h0, 32'hFFFF_FFFF, 16'h0000, 18'h20000, 18'h3FFFE);
    dates = '{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFE};
    foreach (dates[i]) send_predicted(dates[i]);
    wait_drained();
    write_all(32'h0, 32'hFFFF_FFFF, 16'h7FFF, 18'h00100, 18'h1FF00);
    foreach (dates[i]) send_predicted(dates[i]);
    wait_drained();

    // Random phases, each with fresh settings; idling on both sides except in the last three.
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    for (int ph = 0; ph < 19; ph++) begin
      case (ph % 4)
        0: write_all($urandom_range(0, 32'h0010_0000), $urandom_range(1, 32'h4000),
                     16'($urandom), 18'($urandom), 18'($urandom));
        1: write_all($urandom, $urandom, 16'($urandom), 18'($urandom), 18'($urandom));
        2: write_all($urandom_range(0, 32'hFFFF), $urandom_range(0, 3),
                     16'($urandom_range(0, 1024)), 18'($urandom_range(0, 65536)),
                     18'($urandom_range(0, 65536)));
        default: write_all(0, $urandom_range(1, 32'h0100_0000),
                           16'($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF),
                           $urandom_range(0, 1) ? 18'h20000 : 18'h1FFFF,
                           $urandom_range(0, 1) ? 18'h20000 : 18'h1FFFF);
      endcase
      if (ph == 5) out_hold = 1'b1;
      if (ph == 16) begin
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end
      repeat (100) send_predicted(pick_date());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
